[rtl/trc_pkg.sv]
// ----------------------------------------------------------------------------
// trc_pkg
// Shared types, codes and pocket geometry for the tool rack clamp transfer.
// ----------------------------------------------------------------------------
package trc_pkg;

  // item operation codes
  localparam logic [1:0] OP_SAMPLE   = 2'd0;
  localparam logic [1:0] OP_POCKET   = 2'd1;
  localparam logic [1:0] OP_SPINDLE  = 2'd2;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  // transfer result codes
  localparam logic [1:0] XFER_NONE = 2'd0;
  localparam logic [1:0] XFER_PUT  = 2'd1;
  localparam logic [1:0] XFER_TAKE = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_AVAILABLE = 3'd0;
  localparam logic [2:0] REG_RACK_X    = 3'd1;
  localparam logic [2:0] REG_RACK_Y    = 3'd2;
  localparam logic [2:0] REG_RACK_Z    = 3'd3;
  localparam logic [2:0] REG_ACTION    = 3'd4;
  localparam logic [2:0] REG_XY_TOL    = 3'd5;
  localparam logic [2:0] REG_Z_TOL     = 3'd6;

  // widest pocket index over the supported pocket counts
  localparam int IDX_MAX_W = 4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_XFER,
    S_CONTACT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic xfer_step;
    logic contact_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic is_sample;
    logic xfer_on;
    logic scan_last;
    logic out_free;
  } status_t;

  // Y offset of a pocket from the rack base in micrometres
  function automatic logic signed [19:0] pocket_off(input logic [IDX_MAX_W-1:0] idx);
    logic signed [19:0] r;
    if (idx == '0) begin
      r = 20'sd210000;
    end else begin
      r = 20'((6 - $signed({1'b0, idx})) * 30000);
    end
    return r;
  endfunction

endpackage

[rtl/trc_ctrl.sv]
// ----------------------------------------------------------------------------
// trc_ctrl
// Sequencer: accept, execute, transfer scan, contact scan, deliver.
// ----------------------------------------------------------------------------
module trc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  trc_pkg::status_t sts,
  output trc_pkg::cmd_t    cmd
);

  trc_pkg::state_t state, state_next;

  // hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= trc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      trc_pkg::S_IDLE: begin
        if (in_valid) state_next = trc_pkg::S_EXEC;
      end
      trc_pkg::S_EXEC: begin
        state_next = sts.is_sample ? trc_pkg::S_XFER : trc_pkg::S_DONE;
      end
      trc_pkg::S_XFER: begin
        if (!sts.xfer_on || sts.scan_last) state_next = trc_pkg::S_CONTACT;
      end
      trc_pkg::S_CONTACT: begin
        if (sts.scan_last) state_next = trc_pkg::S_DONE;
      end
      trc_pkg::S_DONE: begin
        if (sts.out_free) state_next = trc_pkg::S_IDLE;
      end
      default: state_next = trc_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      trc_pkg::S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      trc_pkg::S_EXEC:    cmd.exec = 1'b1;
      trc_pkg::S_XFER:    cmd.xfer_step = sts.xfer_on;
      trc_pkg::S_CONTACT: cmd.contact_step = 1'b1;
      trc_pkg::S_DONE:    cmd.finish = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

[rtl/trc_dp.sv]
// ----------------------------------------------------------------------------
// trc_dp
// Datapath: registers, clamp hysteresis, pocket table, one-pocket scan unit.
// ----------------------------------------------------------------------------
module trc_dp #(
  parameter int POCKETS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [20:0]         cfg_data,
  input  logic [1:0]          op,
  input  logic signed [20:0]  spindle_x,
  input  logic signed [20:0]  spindle_y,
  input  logic signed [20:0]  spindle_z,
  input  logic signed [20:0]  clamp_pos,
  input  logic [2:0]          pocket_index,
  input  logic [19:0]         tool_number,
  input  logic [19:0]         tool_length,
  input  logic                occupied,
  input  logic                installed,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                clamp_changed,
  output logic                clamped,
  output logic                contact,
  output logic [1:0]          transfer,
  output logic [2:0]          transfer_pocket,
  output logic                spindle_loaded,
  output logic [19:0]         spindle_tool_out,
  input  trc_pkg::cmd_t       cmd,
  output trc_pkg::status_t    sts
);

  localparam int PW = (POCKETS > 1) ? $clog2(POCKETS) : 1;

  // configuration
  logic               rack_available;
  logic signed [20:0] rack_x, rack_y, rack_z;
  logic signed [14:0] clamp_action;
  logic [13:0]        xy_tolerance, z_tolerance;

  // item registers
  logic [1:0]         i_op;
  logic signed [20:0] i_sx, i_sy, i_sz, i_pos;
  logic [2:0]         i_pidx;
  logic [19:0]        i_tool, i_len;
  logic               i_occ, i_inst;

  // block state
  logic [POCKETS-1:0] pocket_present, pocket_full;
  logic [19:0]        pocket_tool [POCKETS];
  logic [19:0]        pocket_length [POCKETS];
  logic               spindle_has;
  logic [19:0]        spindle_tool_id, spindle_length;
  logic               clamp_closed, last_seen_valid;
  logic signed [20:0] last_clamp, clamp_reference;

  // per-item working state
  logic          changed;
  logic [1:0]    mode;
  logic          xfer_done;
  logic [1:0]    xfer_code;
  logic [PW-1:0] xfer_idx;
  logic          contact_hit;
  logic [PW-1:0] idx;

  // write configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      rack_available <= 1'b0;
      rack_x         <= '0;
      rack_y         <= '0;
      rack_z         <= '0;
      clamp_action   <= 15'sd1000;
      xy_tolerance   <= 14'd2000;
      z_tolerance    <= 14'd3000;
    end else if (cfg_we) begin
      case (cfg_index)
        trc_pkg::REG_AVAILABLE: rack_available <= cfg_data[0];
        trc_pkg::REG_RACK_X:    rack_x         <= cfg_data;
        trc_pkg::REG_RACK_Y:    rack_y         <= cfg_data;
        trc_pkg::REG_RACK_Z:    rack_z         <= cfg_data;
        trc_pkg::REG_ACTION:    clamp_action   <= cfg_data[14:0];
        trc_pkg::REG_XY_TOL:    xy_tolerance   <= cfg_data[13:0];
        trc_pkg::REG_Z_TOL:     z_tolerance    <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  // capture item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      i_op   <= op;
      i_sx   <= spindle_x;
      i_sy   <= spindle_y;
      i_sz   <= spindle_z;
      i_pos  <= clamp_pos;
      i_pidx <= pocket_index;
      i_tool <= tool_number;
      i_len  <= tool_length;
      i_occ  <= occupied;
      i_inst <= installed;
    end
  end

  // clamp hysteresis
  logic signed [21:0] delta, travel;
  logic signed [24:0] d_ext, d5, a4;
  logic [15:0]        act;
  logic               hit;
  logic               closed_new;
  always_comb begin
    delta  = 22'(i_pos) - 22'(last_clamp);
    travel = clamp_closed ? 22'(clamp_reference) - 22'(i_pos)
                          : 22'(i_pos) - 22'(clamp_reference);
    act    = clamp_action[14] ? 16'(-$signed({clamp_action[14], clamp_action}))
                              : 16'(clamp_action);
    d_ext  = 25'(travel);
    d5     = (d_ext <<< 2) + d_ext;
    a4     = $signed({7'd0, act, 2'b00});
    hit    = last_seen_valid && (delta != 0) && !(clamp_closed && delta > 0)
             && !(!clamp_closed && delta < 0) && (travel >= 22'sd50) && (d5 >= a4);
    closed_new = hit ? !clamp_closed : clamp_closed;
  end

  // pocket geometry at the scan index
  logic signed [19:0] off;
  logic signed [22:0] dx, dy, dz, ax, ay, az;
  logic               near, at_xfer, xfer_match;
  always_comb begin
    off  = trc_pkg::pocket_off(trc_pkg::IDX_MAX_W'(idx));
    dx   = 23'(i_sx) - 23'(rack_x);
    dy   = 23'(i_sy) - (23'(rack_y) + 23'(off));
    dz   = 23'(i_sz) - 23'(rack_z);
    ax   = dx[22] ? -dx : dx;
    ay   = dy[22] ? -dy : dy;
    az   = dz[22] ? -dz : dz;
    near = (ax <= $signed({9'd0, xy_tolerance})) && (ay <= $signed({9'd0, xy_tolerance}));
    at_xfer = near && (az <= $signed({9'd0, z_tolerance}));
    xfer_match = !xfer_done && pocket_present[idx] && at_xfer
                 && ((mode == trc_pkg::XFER_PUT) || pocket_full[idx]);
  end

  // execute item, then scan
  always_ff @(posedge clk) begin
    if (rst) begin
      pocket_present  <= '0;
      pocket_full     <= '0;
      spindle_has     <= 1'b0;
      spindle_tool_id <= '0;
      spindle_length  <= '0;
      clamp_closed    <= 1'b1;
      last_seen_valid <= 1'b0;
      last_clamp      <= '0;
      clamp_reference <= '0;
    end else if (cmd.exec) begin
      case (i_op)
        trc_pkg::OP_SAMPLE: begin
          last_seen_valid <= 1'b1;
          last_clamp      <= i_pos;
          if (!last_seen_valid || hit) begin
            clamp_reference <= i_pos;
          end else if (clamp_closed && delta > 0 && i_pos > clamp_reference) begin
            clamp_reference <= i_pos;
          end else if (!clamp_closed && delta < 0 && i_pos < clamp_reference) begin
            clamp_reference <= i_pos;
          end
          clamp_closed <= closed_new;
        end
        trc_pkg::OP_POCKET: begin
          if (32'(i_pidx) < POCKETS) begin
            pocket_present[PW'(i_pidx)] <= 1'b1;
            pocket_full[PW'(i_pidx)]    <= i_occ;
          end
        end
        trc_pkg::OP_SPINDLE: begin
          spindle_has     <= i_inst;
          spindle_tool_id <= i_inst ? i_tool : '0;
          spindle_length  <= i_inst ? i_len : '0;
        end
        default: ;
      endcase
    end else if (cmd.xfer_step && xfer_match) begin
      if (mode == trc_pkg::XFER_PUT) begin
        pocket_full[idx] <= 1'b1;
        spindle_has      <= 1'b0;
        spindle_tool_id  <= '0;
        spindle_length   <= '0;
      end else begin
        pocket_full[idx] <= 1'b0;
        spindle_has      <= 1'b1;
        spindle_tool_id  <= pocket_tool[idx];
        spindle_length   <= pocket_length[idx];
      end
    end
  end

  // pocket tool data, no reset
  always_ff @(posedge clk) begin
    if (cmd.exec && i_op == trc_pkg::OP_POCKET && 32'(i_pidx) < POCKETS) begin
      pocket_tool[PW'(i_pidx)]   <= i_tool;
      pocket_length[PW'(i_pidx)] <= i_len;
    end else if (cmd.xfer_step && xfer_match && mode == trc_pkg::XFER_PUT) begin
      pocket_tool[idx]   <= spindle_tool_id;
      pocket_length[idx] <= spindle_length;
    end
  end

  // per-item flags and scan index
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      changed     <= (i_op == trc_pkg::OP_SAMPLE) && hit;
      xfer_done   <= 1'b0;
      xfer_code   <= trc_pkg::XFER_NONE;
      xfer_idx    <= '0;
      contact_hit <= 1'b0;
      idx         <= '0;
      mode        <= trc_pkg::XFER_NONE;
      if (i_op == trc_pkg::OP_SAMPLE && hit && rack_available) begin
        if (!closed_new && spindle_has) mode <= trc_pkg::XFER_PUT;
        if (closed_new && !spindle_has) mode <= trc_pkg::XFER_TAKE;
      end
    end else if (cmd.xfer_step) begin
      if (xfer_match) begin
        xfer_done <= 1'b1;
        xfer_code <= mode;
        xfer_idx  <= idx;
      end
      idx <= sts.scan_last ? '0 : idx + 1'b1;
    end else if (cmd.contact_step) begin
      if (rack_available && pocket_present[idx] && pocket_full[idx] && near) begin
        contact_hit <= 1'b1;
      end
      idx <= sts.scan_last ? '0 : idx + 1'b1;
    end
  end

  // status
  always_comb begin
    sts.is_sample = (i_op == trc_pkg::OP_SAMPLE);
    sts.xfer_on   = (mode != trc_pkg::XFER_NONE);
    sts.scan_last = (idx == PW'(POCKETS - 1));
    sts.out_free  = !out_valid || !out_stall;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      clamp_changed    <= changed && sts.is_sample;
      clamped          <= clamp_closed;
      contact          <= contact_hit && sts.is_sample;
      transfer         <= sts.is_sample ? xfer_code : trc_pkg::XFER_NONE;
      transfer_pocket  <= sts.is_sample ? 3'(xfer_idx) : 3'd0;
      spindle_loaded   <= spindle_has;
      spindle_tool_out <= spindle_tool_id;
    end
  end

`ifndef SYNTHESIS
  a_xfer_needs_toggle: assert property (@(posedge clk) disable iff (rst)
    out_valid && transfer != trc_pkg::XFER_NONE |-> clamp_changed)
    else $error("transfer without clamp toggle");
  a_put_empties: assert property (@(posedge clk) disable iff (rst)
    out_valid && transfer == trc_pkg::XFER_PUT |-> !spindle_loaded && !clamped)
    else $error("put left spindle loaded");
  a_take_loads: assert property (@(posedge clk) disable iff (rst)
    out_valid && transfer == trc_pkg::XFER_TAKE |-> spindle_loaded && clamped)
    else $error("take left spindle empty");
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    !spindle_has |-> spindle_tool_id == '0)
    else $error("empty spindle holds a tool number");
`endif

endmodule

[rtl/tool_rack_clamp_transfer.sv]
// From accept to result valid: a write executes and delivers; a clamp sample
// also runs a contact scan, and a toggle that starts a transfer runs a transfer
// scan before it; the scan unit checks one pocket per cycle.
// Throughput: one item at a time, the next accept in the cycle after the result
// loads, plus any output stall.
// Reset: synchronous, clears configuration, pocket flags, spindle and clamp state.
// ----------------------------------------------------------------------------
// tool_rack_clamp_transfer
// Tool rack model: clamp hysteresis, tool put/take at the rack, contact report.
// ----------------------------------------------------------------------------
module tool_rack_clamp_transfer #(
  parameter int POCKETS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [20:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         op,
  input  logic signed [20:0] spindle_x,
  input  logic signed [20:0] spindle_y,
  input  logic signed [20:0] spindle_z,
  input  logic signed [20:0] clamp_pos,
  input  logic [2:0]         pocket_index,
  input  logic [19:0]        tool_number,
  input  logic [19:0]        tool_length,
  input  logic               occupied,
  input  logic               installed,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               clamp_changed,
  output logic               clamped,
  output logic               contact,
  output logic [1:0]         transfer,
  output logic [2:0]         transfer_pocket,
  output logic               spindle_loaded,
  output logic [19:0]        spindle_tool_out
);

  trc_pkg::cmd_t    cmd;
  trc_pkg::status_t sts;

  // sequencer
  trc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  trc_dp #(.POCKETS(POCKETS)) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .op               (op),
    .spindle_x        (spindle_x),
    .spindle_y        (spindle_y),
    .spindle_z        (spindle_z),
    .clamp_pos        (clamp_pos),
    .pocket_index     (pocket_index),
    .tool_number      (tool_number),
    .tool_length      (tool_length),
    .occupied         (occupied),
    .installed        (installed),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .clamp_changed    (clamp_changed),
    .clamped          (clamped),
    .contact          (contact),
    .transfer         (transfer),
    .transfer_pocket  (transfer_pocket),
    .spindle_loaded   (spindle_loaded),
    .spindle_tool_out (spindle_tool_out),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives clamp samples and rack writes into the tool rack block, predicts
// clamp toggles, tool put/take and contact, and checks every result item.
// ----------------------------------------------------------------------------
module testbench;

  localparam int NPOCK   = 8;
  localparam int WD_MAX  = 20000;
  localparam int SETTLE  = 40;

  typedef struct {
    logic [1:0]         op;
    logic signed [20:0] sx, sy, sz, cpos;
    logic [2:0]         pidx;
    logic [19:0]        tool, len;
    logic               occ, inst;
  } rack_item_t;

  typedef struct {
    logic       changed, closed, cont;
    logic [1:0] xfer;
    logic [2:0] xpocket;
    logic       loaded;
    logic [19:0] tool;
  } rack_result_t;

  logic clk, rst;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [20:0] cfg_data;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [1:0] op;
  logic signed [20:0] spindle_x, spindle_y, spindle_z, clamp_pos;
  logic [2:0] pocket_index;
  logic [19:0] tool_number, tool_length;
  logic occupied, installed;
  logic clamp_changed, clamped, contact, spindle_loaded;
  logic [1:0] transfer;
  logic [2:0] transfer_pocket;
  logic [19:0] spindle_tool_out;

  tool_rack_clamp_transfer u_dut (.*);

  // predictor copy of configuration and state
  logic        m_avail;
  longint      m_rx, m_ry, m_rz, m_act, m_xytol, m_ztol;
  logic        p_present[NPOCK], p_full[NPOCK];
  logic [19:0] p_tool[NPOCK], p_len[NPOCK];
  logic        s_has;
  logic [19:0] s_tool, s_len;
  logic        c_closed, c_seen;
  longint      c_last, c_ref;

  rack_item_t   pending_items[$];
  rack_result_t expected_results[$];
  int  errors = 0;
  int  hold_off = 0;
  int  rx_gap = 0;
  int  idle_cycles = 0;
  bit  long_hold_req = 0;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic longint adiff(longint a, longint b);
    return a > b ? a - b : b - a;
  endfunction

  function automatic longint pocket_y_at(int i);
    return m_ry + ((i == 0) ? 210000 : (6 - i) * 30000);
  endfunction

  function automatic bit over_pocket(int i, longint x, longint y);
    return adiff(x, m_rx) <= m_xytol && adiff(y, pocket_y_at(i)) <= m_xytol;
  endfunction

  function automatic void write_reg(logic [2:0] idx, logic [20:0] v);
    case (idx)
      trc_pkg::REG_AVAILABLE: m_avail = v[0];
      trc_pkg::REG_RACK_X:    m_rx = longint'($signed(v));
      trc_pkg::REG_RACK_Y:    m_ry = longint'($signed(v));
      trc_pkg::REG_RACK_Z:    m_rz = longint'($signed(v));
      trc_pkg::REG_ACTION:    m_act = longint'($signed(v[14:0]));
      trc_pkg::REG_XY_TOL:    m_xytol = longint'(v[13:0]);
      trc_pkg::REG_Z_TOL:     m_ztol = longint'(v[13:0]);
      default: ;
    endcase
  endfunction

  // compute the result of one rack item and update the model state
  function automatic rack_result_t rack_predict(rack_item_t it);
    rack_result_t r;
    longint pos, dlt, act, d, x, y, z;
    r = '{default: 0};
    x = it.sx; y = it.sy; z = it.sz; pos = it.cpos;
    if (it.op == trc_pkg::OP_SAMPLE) begin
      if (!c_seen) begin
        c_seen = 1; c_last = pos; c_ref = pos;
      end else begin
        dlt = pos - c_last;
        act = m_act < 0 ? -m_act : m_act;
        c_last = pos;
        if (c_closed && dlt > 0) begin
          if (pos > c_ref) c_ref = pos;
        end else if (!c_closed && dlt < 0) begin
          if (pos < c_ref) c_ref = pos;
        end else if (dlt != 0) begin
          d = c_closed ? c_ref - pos : pos - c_ref;
          if (d >= 50 && 5 * d >= 4 * act) begin
            c_closed = !c_closed; c_ref = pos; r.changed = 1;
          end
        end
      end
      if (r.changed && m_avail) begin
        for (int i = 0; i < NPOCK; i++) begin
          if (p_present[i] && over_pocket(i, x, y) && adiff(z, m_rz) <= m_ztol &&
              r.xfer == trc_pkg::XFER_NONE) begin
            if (!c_closed && s_has) begin
              p_tool[i] = s_tool; p_len[i] = s_len; p_full[i] = 1;
              s_has = 0; s_tool = 0; s_len = 0;
              r.xfer = trc_pkg::XFER_PUT; r.xpocket = i[2:0];
            end else if (c_closed && !s_has && p_full[i]) begin
              s_has = 1; s_tool = p_tool[i]; s_len = p_len[i]; p_full[i] = 0;
              r.xfer = trc_pkg::XFER_TAKE; r.xpocket = i[2:0];
            end
          end
        end
      end
      if (m_avail)
        for (int i = 0; i < NPOCK; i++)
          if (p_present[i] && p_full[i] && over_pocket(i, x, y)) r.cont = 1;
    end else if (it.op == trc_pkg::OP_POCKET) begin
      p_present[it.pidx] = 1; p_tool[it.pidx] = it.tool;
      p_len[it.pidx] = it.len; p_full[it.pidx] = it.occ;
    end else if (it.op == trc_pkg::OP_SPINDLE) begin
      s_has = it.inst;
      s_tool = it.inst ? it.tool : '0;
      s_len = it.inst ? it.len : '0;
    end
    r.closed = c_closed; r.loaded = s_has; r.tool = s_tool;
    return r;
  endfunction

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // sender: present pending items, hold while stalled
  int in_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid)
        expected_results.insert(expected_results.size(),
                                rack_predict(pending_items.pop_front()));
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 0;
      end else if (pending_items.size() > 0) begin
        in_valid     <= 1;
        op           <= pending_items[0].op;
        spindle_x    <= pending_items[0].sx;
        spindle_y    <= pending_items[0].sy;
        spindle_z    <= pending_items[0].sz;
        clamp_pos    <= pending_items[0].cpos;
        pocket_index <= pending_items[0].pidx;
        tool_number  <= pending_items[0].tool;
        tool_length  <= pending_items[0].len;
        occupied     <= pending_items[0].occ;
        installed    <= pending_items[0].inst;
        in_gap       <= gap_len();
      end else begin
        in_valid <= 0;
      end
    end
  end

  // receiver: random stalls of random length, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
      hold_off  <= 0;
      rx_gap    <= 0;
    end else if (long_hold_req && hold_off == 0) begin
      hold_off <= 300;
      out_stall <= 1;
    end else if (hold_off > 1) begin
      hold_off <= hold_off - 1;
    end else if (rx_gap > 0) begin
      hold_off <= 0;
      rx_gap <= rx_gap - 1;
      out_stall <= 1;
    end else begin
      hold_off <= 0;
      if ($urandom_range(0, 99) < 25) begin
        rx_gap <= gap_len();
        out_stall <= 1;
      end else begin
        out_stall <= 0;
      end
    end
  end

  // check each accepted result against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result with no expectation waiting");
        errors++;
      end else begin
        rack_result_t e;
        e = expected_results.pop_front();
        if (clamp_changed !== e.changed) begin
          $error("clamp_changed exp %0d got %0d", e.changed, clamp_changed); errors++;
        end
        if (clamped !== e.closed) begin
          $error("clamped exp %0d got %0d", e.closed, clamped); errors++;
        end
        if (contact !== e.cont) begin
          $error("contact exp %0d got %0d", e.cont, contact); errors++;
        end
        if (transfer !== e.xfer) begin
          $error("transfer exp %0d got %0d", e.xfer, transfer); errors++;
        end
        if (transfer_pocket !== e.xpocket) begin
          $error("transfer_pocket exp %0d got %0d", e.xpocket, transfer_pocket); errors++;
        end
        if (spindle_loaded !== e.loaded) begin
          $error("spindle_loaded exp %0d got %0d", e.loaded, spindle_loaded); errors++;
        end
        if (spindle_tool_out !== e.tool) begin
          $error("spindle_tool_out exp %0d got %0d", e.tool, spindle_tool_out); errors++;
        end
      end
    end
  end

  // watchdog on cycles with no accepted item
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WD_MAX) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [20:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    write_reg(idx, v);
    cfg_we <= 0;
  endtask

  function automatic rack_item_t blank_item();
    rack_item_t it;
    it.op = trc_pkg::OP_SAMPLE; it.sx = 0; it.sy = 0; it.sz = 0; it.cpos = 0;
    it.pidx = 0; it.tool = 0; it.len = 0; it.occ = 0; it.inst = 0;
    return it;
  endfunction

  function automatic logic signed [20:0] rnd_pos();
    return 21'($signed($urandom_range(0, 2000000)) - 1000000);
  endfunction

  // sample near a pocket, or at random coordinates, with a given clamp position
  function automatic void push_sample(longint cpos, int pk, bit near);
    rack_item_t it;
    it = blank_item();
    it.cpos = 21'(cpos);
    if (near) begin
      it.sx = 21'(m_rx + $signed($urandom_range(0, 2 * m_xytol)) - m_xytol);
      it.sy = 21'(pocket_y_at(pk) + $signed($urandom_range(0, 2 * m_xytol)) - m_xytol);
      it.sz = 21'(m_rz + $signed($urandom_range(0, 2 * m_ztol + 200)) - m_ztol - 100);
    end else begin
      it.sx = rnd_pos(); it.sy = rnd_pos(); it.sz = rnd_pos();
    end
    pending_items.insert(pending_items.size(), it);
  endfunction

  function automatic void push_write(bit spindle, int pk);
    rack_item_t it;
    it = blank_item();
    it.op = spindle ? trc_pkg::OP_SPINDLE : trc_pkg::OP_POCKET;
    it.sx = rnd_pos(); it.sy = rnd_pos(); it.sz = rnd_pos(); it.cpos = rnd_pos();
    it.pidx = pk[2:0];
    it.tool = 20'($urandom);
    it.len = 20'($urandom_range(0, 1048575));
    it.occ = 1'($urandom_range(0, 1));
    it.inst = $urandom_range(0, 3) != 0;
    pending_items.insert(pending_items.size(), it);
  endfunction

  // random phase: toggle-hunting clamp walks mixed with writes and noise
  task automatic random_phase(int n);
    longint cp;
    int pk;
    cp = $urandom_range(0, 20000);
    for (int k = 0; k < n; k++) begin
      int sel;
      rack_item_t it;
      sel = $urandom_range(0, 99);
      pk = $urandom_range(0, NPOCK - 1);
      if (sel < 12) begin
        push_write(0, pk);
      end else if (sel < 18) begin
        push_write(1, 0);
      end else if (sel < 22) begin
        it = blank_item();
        it.op = trc_pkg::OP_RESERVED; it.sx = rnd_pos(); it.cpos = rnd_pos();
        it.tool = 20'($urandom);
        pending_items.insert(pending_items.size(), it);
      end else if (sel < 27) begin
        push_sample(rnd_pos(), pk, 0);
      end else begin
        cp += $signed($urandom_range(0, 3000)) - 1500;
        if ($urandom_range(0, 3) == 0) cp += ($urandom_range(0, 1) ? 1 : -1) * (m_act + 60);
        if (cp > 1000000) cp = 1000000;
        if (cp < -1000000) cp = -1000000;
        push_sample(cp, pk, $urandom_range(0, 9) < 8);
      end
    end
  endtask

  initial begin
    rack_item_t it;
    rst = 1; cfg_we = 0; cfg_index = trc_pkg::REG_AVAILABLE; cfg_data = 0;
    in_valid = 0; out_stall = 0;
    op = trc_pkg::OP_SAMPLE; spindle_x = 0; spindle_y = 0; spindle_z = 0; clamp_pos = 0;
    pocket_index = 0; tool_number = 0; tool_length = 0; occupied = 0; installed = 0;
    m_avail = 0; m_rx = 0; m_ry = 0; m_rz = 0; m_act = 1000; m_xytol = 2000; m_ztol = 3000;
    for (int i = 0; i < NPOCK; i++) begin
      p_present[i] = 0; p_full[i] = 0; p_tool[i] = 0; p_len[i] = 0;
    end
    s_has = 0; s_tool = 0; s_len = 0; c_closed = 1; c_seen = 0; c_last = 0; c_ref = 0;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: rack unavailable first, then enable, load pockets and spindle, and sample the clamp
    push_sample(-1000000, 0, 1);
    push_sample(1000000, 0, 1);
    push_sample(-1000000, 0, 1);
    drain();
    cfg_write(trc_pkg::REG_AVAILABLE, 21'd1);
    cfg_write(trc_pkg::REG_RACK_X, 21'd0);
    cfg_write(trc_pkg::REG_RACK_Y, 21'd0);
    cfg_write(trc_pkg::REG_RACK_Z, 21'd0);
    cfg_write(trc_pkg::REG_ACTION, 21'd1000);
    cfg_write(trc_pkg::REG_XY_TOL, 21'd2000);
    cfg_write(trc_pkg::REG_Z_TOL, 21'd3000);
    for (int i = 0; i < NPOCK; i++) begin
      it = blank_item(); it.op = trc_pkg::OP_POCKET; it.pidx = i[2:0];
      it.tool = (i == 7) ? 20'hFFFFF : 20'(i + 1); it.len = 20'(i * 1000);
      it.occ = i[0];
      pending_items.insert(pending_items.size(), it);
    end
    it = blank_item(); it.op = trc_pkg::OP_SPINDLE; it.inst = 1; it.tool = 20'd77;
    it.len = 20'hFFFFF;
    pending_items.insert(pending_items.size(), it);
    push_sample(-1000000, 0, 1);   // clamp already open, no toggle: no park into pocket 0
    push_sample(1000000, 1, 1);    // close with the spindle loaded: no take from pocket 1
    push_sample(999951, 1, 1);
    push_sample(999950, 1, 1);     // minimum travel reached, still below the action threshold
    it = blank_item(); it.op = trc_pkg::OP_SPINDLE; it.inst = 0;
    pending_items.insert(pending_items.size(), it);
    it = blank_item(); it.op = trc_pkg::OP_RESERVED; it.pidx = 3'd7; it.occ = 1; it.inst = 1;
    pending_items.insert(pending_items.size(), it);
    drain();

    // extremes of the registers
    cfg_write(trc_pkg::REG_ACTION, 21'(-10000));
    cfg_write(trc_pkg::REG_XY_TOL, 21'd10000);
    cfg_write(trc_pkg::REG_Z_TOL, 21'd0);
    cfg_write(trc_pkg::REG_RACK_X, 21'(-1000000));
    cfg_write(trc_pkg::REG_RACK_Y, 21'd1000000);
    cfg_write(trc_pkg::REG_RACK_Z, 21'(-1000000));
    random_phase(300);
    drain();

    // exercise a long receiver hold-off
    cfg_write(trc_pkg::REG_RACK_X, 21'd1000000);
    cfg_write(trc_pkg::REG_RACK_Y, 21'(-1000000));
    cfg_write(trc_pkg::REG_RACK_Z, 21'd1000000);
    cfg_write(trc_pkg::REG_ACTION, 21'd10000);
    cfg_write(trc_pkg::REG_XY_TOL, 21'd0);
    cfg_write(trc_pkg::REG_Z_TOL, 21'd10000);
    long_hold_req = 1;
    random_phase(200);
    wait (hold_off > 0);
    long_hold_req = 0;
    drain();

    cfg_write(trc_pkg::REG_RACK_X, 21'd1234);
    cfg_write(trc_pkg::REG_RACK_Y, 21'(-5678));
    cfg_write(trc_pkg::REG_RACK_Z, 21'd999);
    cfg_write(trc_pkg::REG_ACTION, 21'd0);
    cfg_write(trc_pkg::REG_XY_TOL, 21'd3000);
    cfg_write(trc_pkg::REG_Z_TOL, 21'd3000);
    random_phase(600);
    drain();

    cfg_write(trc_pkg::REG_ACTION, 21'd40);
    cfg_write(trc_pkg::REG_AVAILABLE, 21'd0);
    random_phase(100);
    drain();
    cfg_write(trc_pkg::REG_AVAILABLE, 21'd1);
    cfg_write(trc_pkg::REG_ACTION, 21'd2500);
    cfg_write(trc_pkg::REG_XY_TOL, 21'h3FFF);
    cfg_write(trc_pkg::REG_Z_TOL, 21'h3FFF);
    random_phase(480);
    drain();

    if (errors == 0 && expected_results.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule
